### rtl/fst_pkg.sv
// fst_pkg: types and constants shared by the flow statistics table.
// No dependencies.
package fst_pkg;
    localparam int unsigned FLOW_ENTRIES = 256;
    localparam int unsigned IDX_W = $clog2(FLOW_ENTRIES);
    localparam int unsigned CNT_W = IDX_W + 1;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [2:0] CLS_UNKNOWN  = 3'd0;
    localparam logic [2:0] CLS_HTTP     = 3'd1;
    localparam logic [2:0] CLS_HTTPS    = 3'd2;
    localparam logic [2:0] CLS_REDIS    = 3'd4;
    localparam logic [2:0] CLS_MYSQL    = 3'd5;
    localparam logic [2:0] CLS_POSTGRES = 3'd6;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port_num;
        logic [15:0] dst_port_num;
        logic [7:0]  ip_proto;
        logic        is_egress;
        logic [15:0] pkt_length;
        logic [63:0] now_ns;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  app_class;
        logic [15:0] service_port;
        logic [31:0] total_packets;
        logic [47:0] flow_bytes;
        logic [31:0] dir_packets;
        logic [47:0] dir_bytes;
        logic [63:0] flow_age_ns;
    } t_rsp;

    typedef struct packed {
        logic [63:0] first_time;
        logic [31:0] pkt_total;
        logic [47:0] byte_total;
        logic [31:0] pkt_in;
        logic [47:0] byte_in;
        logic [31:0] pkt_eg;
        logic [47:0] byte_eg;
        logic [15:0] svc_port;
        logic [2:0]  svc_class;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             cmp_en;
        logic             wr_hit;
        logic             wr_new;
        logic             rsp_full;
        logic [IDX_W-1:0] wr_idx;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;
    } t_sts;

    function automatic logic [2:0] port_class(input logic [15:0] port);
        logic [2:0] c;
        case (port)
            16'd80:   c = CLS_HTTP;
            16'd443:  c = CLS_HTTPS;
            16'd3306: c = CLS_MYSQL;
            16'd5432: c = CLS_POSTGRES;
            16'd6379: c = CLS_REDIS;
            default:  c = CLS_UNKNOWN;
        endcase
        return c;
    endfunction
endpackage

### rtl/fst_if.sv
// fst_req_if / fst_rsp_if: valid-ready channels for requests and results.
// Depends on fst_pkg.
interface fst_req_if import fst_pkg::*;;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fst_rsp_if import fst_pkg::*;;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/fst_ctrl.sv
// fst_ctrl: sequencer for search, hit update and insert of one request.
// Depends on fst_pkg. Owns the valid bits.
module fst_ctrl import fst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output t_cmd       o_cmd,
    input  t_sts       i_sts
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHECK, S_WRITE, S_OUT} t_state;

    t_state                 r_state;
    logic [FLOW_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_chk_idx;
    logic                   r_chk;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free_idx;
    logic                   r_rsp_valid;
    logic                   n_hit;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign n_hit = r_chk && i_sts.match && !r_hit;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_req_valid;
        o_cmd.rd_idx = r_idx[IDX_W-1:0];
        o_cmd.rd_en = (r_state == S_SCAN) && r_valid[r_idx[IDX_W-1:0]] && !r_hit && !n_hit;
        o_cmd.cmp_en = r_chk;
        o_cmd.wr_idx = r_hit ? r_hit_idx : r_free_idx;
        if (r_state == S_WRITE) begin
            o_cmd.wr_hit = r_hit;
            o_cmd.wr_new = !r_hit && r_free_found;
            o_cmd.rsp_full = !r_hit && !r_free_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_idx <= '0;
            r_chk <= 1'b0;
            r_hit <= 1'b0;
            r_free_found <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= S_SCAN;
                        r_idx <= '0;
                        r_chk <= 1'b0;
                        r_hit <= 1'b0;
                        r_free_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_chk <= o_cmd.rd_en;
                    r_chk_idx <= r_idx[IDX_W-1:0];
                    if (n_hit) begin
                        r_hit <= 1'b1;
                        r_hit_idx <= r_chk_idx;
                    end
                    if (!r_valid[r_idx[IDX_W-1:0]] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx <= r_idx[IDX_W-1:0];
                    end
                    if (r_idx == CNT_W'(FLOW_ENTRIES - 1)) begin
                        r_state <= S_CHECK;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_CHECK: begin
                    r_chk <= 1'b0;
                    if (n_hit) begin
                        r_hit <= 1'b1;
                        r_hit_idx <= r_chk_idx;
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!r_hit && r_free_found) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_rsp_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_rsp_ready) begin
                        r_rsp_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/fst_dp.sv
// fst_dp: request register, entry memories, key compare and result register.
// Depends on fst_pkg.
module fst_dp import fst_pkg::*; (
    input  logic i_clk,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp
);
    logic [63:0] r_key_mem0 [FLOW_ENTRIES];
    logic [63:0] r_key_mem1 [FLOW_ENTRIES];
    t_entry      r_ent_mem  [FLOW_ENTRIES];
    t_req        r_req;
    logic [63:0] r_k0_rd;
    logic [63:0] r_k1_rd;
    t_entry      r_ent_rd;
    t_rsp        r_rsp;
    logic [63:0] k0;
    logic [63:0] k1;
    t_entry      n_ent;
    t_rsp        n_rsp;
    logic [15:0] n_port;

    assign k0 = {r_req.src_addr, r_req.dst_addr};
    assign k1 = {23'd0, r_req.src_port_num, r_req.dst_port_num, r_req.ip_proto,
                 r_req.is_egress};
    assign o_sts.match = i_cmd.cmp_en && (r_k0_rd == k0) && (r_k1_rd == k1);
    assign o_rsp = r_rsp;
    assign n_port = r_req.is_egress ? r_req.src_port_num : r_req.dst_port_num;

    always_comb begin
        n_ent = r_ent_rd;
        n_ent.pkt_total = r_ent_rd.pkt_total + 32'd1;
        n_ent.byte_total = r_ent_rd.byte_total + 48'(r_req.pkt_length);
        if (r_req.is_egress) begin
            n_ent.pkt_eg = r_ent_rd.pkt_eg + 32'd1;
            n_ent.byte_eg = r_ent_rd.byte_eg + 48'(r_req.pkt_length);
        end else begin
            n_ent.pkt_in = r_ent_rd.pkt_in + 32'd1;
            n_ent.byte_in = r_ent_rd.byte_in + 48'(r_req.pkt_length);
        end
        if (i_cmd.wr_new) begin
            n_ent = '0;
            n_ent.first_time = r_req.now_ns;
            n_ent.pkt_total = 32'd1;
            n_ent.byte_total = 48'(r_req.pkt_length);
            n_ent.svc_port = n_port;
            n_ent.svc_class = port_class(n_port);
        end
    end

    always_comb begin
        n_rsp = '0;
        if (i_cmd.rsp_full) begin
            n_rsp.status = ST_FULL;
        end else begin
            n_rsp.status = i_cmd.wr_new ? ST_CREATED : ST_UPDATED;
            n_rsp.app_class = n_ent.svc_class;
            n_rsp.service_port = n_ent.svc_port;
            n_rsp.total_packets = n_ent.pkt_total;
            n_rsp.flow_bytes = n_ent.byte_total;
            if (i_cmd.wr_hit) begin
                n_rsp.dir_packets = r_req.is_egress ? n_ent.pkt_eg : n_ent.pkt_in;
                n_rsp.dir_bytes = r_req.is_egress ? n_ent.byte_eg : n_ent.byte_in;
                n_rsp.flow_age_ns = r_req.now_ns - r_ent_rd.first_time;
            end
        end
    end

    // read stays registered after the hit so the matched entry is held
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.rd_en) begin
            r_k0_rd <= r_key_mem0[i_cmd.rd_idx];
            r_k1_rd <= r_key_mem1[i_cmd.rd_idx];
            r_ent_rd <= r_ent_mem[i_cmd.rd_idx];
        end
        if (i_cmd.wr_hit || i_cmd.wr_new) begin
            r_ent_mem[i_cmd.wr_idx] <= n_ent;
        end
        if (i_cmd.wr_new) begin
            r_key_mem0[i_cmd.wr_idx] <= k0;
            r_key_mem1[i_cmd.wr_idx] <= k1;
        end
        if (i_cmd.wr_hit || i_cmd.wr_new || i_cmd.rsp_full) begin
            r_rsp <= n_rsp;
        end
    end
endmodule

### rtl/flow_stats_table_top.sv
// Flow statistics table: one request in, one result out per packet. For each
// request the controller walks every entry through the single read port of
// each key memory one per cycle, then does one read-modify-write of the hit
// or free entry, then holds the result for the output handshake. A new
// request is taken only after the previous result is taken.
// Depends on fst_pkg, fst_if, fst_ctrl, fst_dp.
module flow_stats_table_top import fst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fst_req_if.sink   i_req,
    fst_rsp_if.source o_rsp
);
    t_cmd cmd;
    t_sts sts;

    fst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    fst_dp u_dp (
        .i_clk (i_clk),
        .i_req (i_req.data),
        .i_cmd (cmd),
        .o_sts (sts),
        .o_rsp (o_rsp.data)
    );
endmodule

### rtl/fst_chk.sv
// fst_chk: port-level checks of the flow statistics table, bound to the top.
// Depends on fst_pkg.
module fst_chk import fst_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input t_rsp o_rsp_data
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && o_rsp_valid)) else $error("request taken while result pending");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_data))
        else $error("result dropped");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp_data.status != 2'd3) else $error("bad status");
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_data.status == ST_FULL |-> o_rsp_data.total_packets == 0)
        else $error("full result not cleared");
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_data.status == ST_CREATED |->
        o_rsp_data.total_packets == 1 && o_rsp_data.flow_age_ns == 0)
        else $error("new flow result wrong");
endmodule

bind flow_stats_table_top fst_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_data  (o_rsp.data)
);

### sim/tb_flow_stats_table_top.sv
// Testbench for flow_stats_table_top: drives random and directed packets,
// predicts each result with a behavioral flow table and compares field by field.
// Depends on fst_pkg, fst_if and the RTL of flow_stats_table_top.
`timescale 1ns / 1ps

module tb_flow_stats_table_top;
    import fst_pkg::*;

    class flow_scoreboard;
        bit          valid_q [FLOW_ENTRIES];
        logic [63:0] key_a [FLOW_ENTRIES];
        logic [63:0] key_b [FLOW_ENTRIES];
        t_entry      tbl [FLOW_ENTRIES];
        t_rsp        pending [$];
        int          errors;

        function void note_request(t_req r);
            logic [63:0] ka, kb;
            t_rsp        o;
            int          hit, fr;
            ka = {r.src_addr, r.dst_addr};
            kb = {23'd0, r.src_port_num, r.dst_port_num, r.ip_proto, r.is_egress};
            hit = -1;
            fr = -1;
            o = '0;
            for (int i = 0; i < FLOW_ENTRIES; i++) begin
                if (valid_q[i]) begin
                    if (hit < 0 && key_a[i] == ka && key_b[i] == kb) hit = i;
                end else if (fr < 0) begin
                    fr = i;
                end
            end
            if (hit >= 0) begin
                tbl[hit].pkt_total += 32'd1;
                tbl[hit].byte_total += 48'(r.pkt_length);
                if (!r.is_egress) begin
                    tbl[hit].pkt_in += 32'd1;
                    tbl[hit].byte_in += 48'(r.pkt_length);
                    o.dir_packets = tbl[hit].pkt_in;
                    o.dir_bytes = tbl[hit].byte_in;
                end else begin
                    tbl[hit].pkt_eg += 32'd1;
                    tbl[hit].byte_eg += 48'(r.pkt_length);
                    o.dir_packets = tbl[hit].pkt_eg;
                    o.dir_bytes = tbl[hit].byte_eg;
                end
                o.status = ST_UPDATED;
                o.app_class = tbl[hit].svc_class;
                o.service_port = tbl[hit].svc_port;
                o.total_packets = tbl[hit].pkt_total;
                o.flow_bytes = tbl[hit].byte_total;
                o.flow_age_ns = r.now_ns - tbl[hit].first_time;
            end else if (fr < 0) begin
                o.status = ST_FULL;
            end else begin
                valid_q[fr] = 1;
                key_a[fr] = ka;
                key_b[fr] = kb;
                tbl[fr] = '0;
                tbl[fr].first_time = r.now_ns;
                tbl[fr].pkt_total = 32'd1;
                tbl[fr].byte_total = 48'(r.pkt_length);
                tbl[fr].svc_port = r.is_egress ? r.src_port_num : r.dst_port_num;
                case (tbl[fr].svc_port)
                    16'd80:   tbl[fr].svc_class = CLS_HTTP;
                    16'd443:  tbl[fr].svc_class = CLS_HTTPS;
                    16'd3306: tbl[fr].svc_class = CLS_MYSQL;
                    16'd5432: tbl[fr].svc_class = CLS_POSTGRES;
                    16'd6379: tbl[fr].svc_class = CLS_REDIS;
                    default:  tbl[fr].svc_class = CLS_UNKNOWN;
                endcase
                o.status = ST_CREATED;
                o.app_class = tbl[fr].svc_class;
                o.service_port = tbl[fr].svc_port;
                o.total_packets = 32'd1;
                o.flow_bytes = 48'(r.pkt_length);
            end
            pending.push_back(o);
        endfunction

        function void check_result(t_rsp a);
            t_rsp e;
            if (pending.size() == 0) begin
                $error("unexpected result %p", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.app_class !== e.app_class) begin
                $error("app_class exp %0d got %0d", e.app_class, a.app_class); errors++;
            end
            if (a.service_port !== e.service_port) begin
                $error("service_port exp %0d got %0d", e.service_port, a.service_port);
                errors++;
            end
            if (a.total_packets !== e.total_packets) begin
                $error("total_packets exp %0d got %0d", e.total_packets, a.total_packets);
                errors++;
            end
            if (a.flow_bytes !== e.flow_bytes) begin
                $error("flow_bytes exp %0d got %0d", e.flow_bytes, a.flow_bytes);
                errors++;
            end
            if (a.dir_packets !== e.dir_packets) begin
                $error("dir_packets exp %0d got %0d", e.dir_packets, a.dir_packets);
                errors++;
            end
            if (a.dir_bytes !== e.dir_bytes) begin
                $error("dir_bytes exp %0d got %0d", e.dir_bytes, a.dir_bytes); errors++;
            end
            if (a.flow_age_ns !== e.flow_age_ns) begin
                $error("flow_age_ns exp %0d got %0d", e.flow_age_ns, a.flow_age_ns);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    fst_req_if req_ch ();
    fst_rsp_if rsp_ch ();
    flow_scoreboard flows;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    t_req flow_pool [64];

    flow_stats_table_top dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink),
                              .o_rsp(rsp_ch.source));

    always #5 i_clk = ~i_clk;

    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        req_ch.valid = 0;
        req_ch.data = '0;
        rsp_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) flows.check_result(rsp_ch.data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ch.ready <= 0;
        end else begin
            rsp_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [15:0] pick_port();
        case ($urandom_range(7))
            0: return 16'd80;
            1: return 16'd443;
            2: return 16'd3306;
            3: return 16'd5432;
            4: return 16'd6379;
            5: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_packet();
        t_req r;
        r.src_addr = $urandom;
        r.dst_addr = $urandom;
        r.src_port_num = pick_port();
        r.dst_port_num = pick_port();
        r.ip_proto = 8'($urandom);
        r.is_egress = 1'($urandom);
        r.pkt_length = 16'($urandom);
        r.now_ns = {$urandom, $urandom};
        return r;
    endfunction

    task automatic send_packet(t_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        flows.note_request(r);
    endtask

    task automatic run_random(int n);
        t_req r;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 8) begin
                r = flow_pool[$urandom_range(63)];
                r.is_egress = 1'($urandom);
                r.pkt_length = 16'($urandom);
                r.now_ns = {$urandom, $urandom};
            end else begin
                r = random_packet();
            end
            send_packet(r);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_ch.valid <= 0;
        while (flows.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        t_req r;
        flows = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every class, both directions, repeats
        r = '0;
        send_packet(r);
        send_packet(r);
        r = '1;
        send_packet(r);
        r.now_ns = 64'd5;
        send_packet(r);
        r.is_egress = 0;
        send_packet(r);
        send_packet(r);
        foreach (flow_pool[i]) flow_pool[i] = random_packet();
        for (int i = 0; i < 5; i++) begin
            r = random_packet();
            r.is_egress = i[0];
            r.dst_port_num = (i == 0) ? 16'd80 : (i == 2) ? 16'd3306 : 16'd6379;
            r.src_port_num = (i == 1) ? 16'd443 : 16'd5432;
            send_packet(r);
            r.is_egress = ~r.is_egress;
            send_packet(r);
        end
        drain();

        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(590);
        send_idle_pct = 63; recv_stall_pct = 0;  run_random(150);
        drain();
        send_idle_pct = 0;  recv_stall_pct = 63; run_random(150);
        hold_off = 2000;
        run_random(20);
        send_idle_pct = 17; recv_stall_pct = 17; run_random(250);
        drain();

        // fill the table, then see drops and hits on a full table
        send_idle_pct = 0;  recv_stall_pct = 0;
        for (int i = 0; i < FLOW_ENTRIES + 20; i++) send_packet(random_packet());
        send_idle_pct = 17; recv_stall_pct = 17;
        run_random(300);
        send_idle_pct = 63; recv_stall_pct = 63;
        run_random(200);
        drain();

        if (flows.errors == 0 && flows.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
